// ===== src/dix_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, status codes and sequencer states of the Dix interval velocity block.
package dix_pkg;

    // Default field widths
    localparam int VELOCITY_BITS  = 16;
    localparam int TIME_BITS      = 22;
    localparam int TIME_FRAC_BITS = 16;
    localparam int STATUS_BITS    = 3;

    // Result status codes
    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK         = 3'd0,
        ST_ZERO_INPUT = 3'd1,
        ST_TIME_ORDER = 3'd2,
        ST_NEG_DVH    = 3'd3,
        ST_SATURATED  = 3'd4
    } status_t;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_MUL_VT,
        S_VT_DONE,
        S_MUL_VVT,
        S_NOW_DONE,
        S_MUL_DT,
        S_SQRT_T,
        S_DIV_WAIT,
        S_SQRT_V,
        S_FINISH,
        S_PUBLISH
    } state_t;

endpackage

// ===== src/dix_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for pick words and layer result words.
interface dix_in_if #(
    parameter int VELOCITY_BITS = dix_pkg::VELOCITY_BITS,
    parameter int TIME_BITS     = dix_pkg::TIME_BITS
);
    logic                     valid;
    logic                     ready;
    logic [VELOCITY_BITS-1:0] stack_velocity;
    logic [TIME_BITS-1:0]     zero_offset_time;
    logic                     first_layer;

    modport source (
        output valid, stack_velocity, zero_offset_time, first_layer,
        input  ready
    );
    modport sink (
        input  valid, stack_velocity, zero_offset_time, first_layer,
        output ready
    );
endinterface

interface dix_out_if #(
    parameter int VELOCITY_BITS = dix_pkg::VELOCITY_BITS,
    parameter int TIME_BITS     = dix_pkg::TIME_BITS
);
    logic                             valid;
    logic                             ready;
    logic [TIME_BITS-1:0]             layer_thickness;
    logic [VELOCITY_BITS-1:0]         interval_velocity;
    logic [dix_pkg::STATUS_BITS-1:0]  status;

    modport source (
        output valid, layer_thickness, interval_velocity, status,
        input  ready
    );
    modport sink (
        input  valid, layer_thickness, interval_velocity, status,
        output ready
    );
endinterface

// ===== src/dix_interval_velocity_core.sv =====
`timescale 1ns / 1ps
// Dix interval velocity core: picks in, layer thickness and interval velocity out.
// One pick word is worked on at a time. A pick rejected for a zero field or a
// non-increasing time goes straight from the check to publication. A first
// layer runs only the v*t and v*v*t multiplies; a later layer goes on to
// dvh*dt, the division and the two roots. The work is done by the bit-per-cycle
// shift-add multiplier, which forms v*t, v*v*t and, for a later layer, dvh*dt
// in turn, and by the shared square-root unit, which makes one root bit per
// cycle from two radicand bits, first for the thickness and then for the
// velocity. The restoring divider for dvh/dt runs beside the last multiply and
// the first root. A new pick is taken as soon as the previous result word is
// in the output register, even if that word has not been taken yet.
module dix_interval_velocity_core #(
    parameter int VELOCITY_BITS  = dix_pkg::VELOCITY_BITS,
    parameter int TIME_BITS      = dix_pkg::TIME_BITS,
    parameter int TIME_FRAC_BITS = dix_pkg::TIME_FRAC_BITS
) (
    input  logic      clk,
    input  logic      rst_n,
    dix_in_if.sink    in_word,
    dix_out_if.source out_word
);

    localparam int VW   = VELOCITY_BITS;
    localparam int TW   = TIME_BITS;
    localparam int SH   = TIME_FRAC_BITS + 1;
    localparam int VTW  = VW + TW;
    localparam int PW   = 2 * VW + TW;
    localparam int QW   = PW + TW;
    localparam int RW   = (QW + 1) / 2;
    localparam int SW   = 2 * RW;
    localparam int RQ   = (PW + 1) / 2;
    localparam int QSH  = SW - 2 * RQ;
    localparam int BW   = (VW > TW) ? VW : TW;
    localparam int KMAX = (BW > RW) ? BW : RW;
    localparam int KW   = $clog2(KMAX + 1);
    localparam int DW   = $clog2(PW + 1);

    // Control state
    dix_pkg::state_t state_reg, state_next;
    logic            out_valid_reg;
    logic [DW-1:0]   dcnt_reg;
    logic [TW-1:0]   prev_time_reg;
    logic [PW-1:0]   prev_prod_reg;

    // Pick registers
    logic [VW-1:0]   v_reg;
    logic [TW-1:0]   t_reg;
    logic            first_reg;
    logic [VTW-1:0]  vt_reg;
    logic [PW-1:0]   now_reg;

    // Shift-add multiplier
    logic [QW-1:0]   mcand_reg;
    logic [BW-1:0]   mplier_reg;
    logic [QW-1:0]   acc_reg;
    logic [KW-1:0]   kcnt_reg;

    // Restoring divider
    logic [PW-1:0]   dnum_reg;
    logic [TW-1:0]   drem_reg;
    logic [TW-1:0]   dden_reg;

    // Square-root unit
    logic [SW-1:0]   sx_reg;
    logic [RW+1:0]   srem_reg;
    logic [RW-1:0]   sroot_reg;
    logic [RW-1:0]   root_t_reg;

    // Result and output registers
    logic [TW-1:0]                    res_thick_reg;
    logic [VW-1:0]                    res_vel_reg;
    dix_pkg::status_t                 res_status_reg;
    logic [TW-1:0]                    out_thick_reg;
    logic [VW-1:0]                    out_vel_reg;
    logic [dix_pkg::STATUS_BITS-1:0]  out_status_reg;

    // Decoded strobes
    logic in_ready;
    logic div_start;
    logic pub_fire;
    logic state_upd;

    // Checks on the held pick
    logic          zero_in;
    logic          time_bad;
    logic          neg_dvh;
    logic [PW-1:0] dvh;
    logic [TW-1:0] dt_now;

    assign zero_in  = (v_reg == '0) || (t_reg == '0);
    assign time_bad = (t_reg <= prev_time_reg);
    assign neg_dvh  = (acc_reg[PW-1:0] < prev_prod_reg);
    assign dvh      = acc_reg[PW-1:0] - prev_prod_reg;
    assign dt_now   = t_reg - prev_time_reg;

    // Multiplier step: add the shifted multiplicand on a set bit
    logic [QW-1:0] acc_step;
    logic          step_last;

    assign acc_step  = mplier_reg[0] ? (acc_reg + mcand_reg) : acc_reg;
    assign step_last = (kcnt_reg == KW'(1));

    // Divider step: one quotient bit per cycle
    logic [TW:0]   dtrial;
    logic [TW:0]   ddiff;
    logic          dfit;

    assign dtrial = {drem_reg, dnum_reg[PW-1]};
    assign ddiff  = dtrial - {1'b0, dden_reg};
    assign dfit   = ~ddiff[TW];

    // Square-root step: one root bit per cycle from two radicand bits
    logic [RW+3:0] strial;
    logic [RW+3:0] scand;
    logic [RW+3:0] sdiff;
    logic          sfit;

    assign strial = {srem_reg, sx_reg[SW-1 -: 2]};
    assign scand  = {2'b00, sroot_reg, 2'b01};
    assign sdiff  = strial - scand;
    assign sfit   = (strial >= scand);

    // Final scaling and clamping
    logic [QW-1:0] thick_wide;
    logic [QW-1:0] vel_wide;
    logic          thick_sat;
    logic          vel_sat;

    assign thick_wide = first_reg ? (QW'(vt_reg) >> SH) : (QW'(root_t_reg) >> SH);
    assign vel_wide   = first_reg ? QW'(v_reg) : QW'(sroot_reg);
    assign thick_sat  = (thick_wide > QW'({TW{1'b1}}));
    assign vel_sat    = (vel_wide > QW'({VW{1'b1}}));

    logic can_pub;
    assign can_pub = !out_valid_reg || out_word.ready;

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dix_pkg::S_IDLE:
            begin
                if (in_word.valid)
                    state_next = dix_pkg::S_CHECK;
            end
            dix_pkg::S_CHECK:
            begin
                if (zero_in || (!first_reg && time_bad))
                    state_next = dix_pkg::S_PUBLISH;
                else
                    state_next = dix_pkg::S_MUL_VT;
            end
            dix_pkg::S_MUL_VT:
            begin
                if (step_last)
                    state_next = dix_pkg::S_VT_DONE;
            end
            dix_pkg::S_VT_DONE:
                state_next = dix_pkg::S_MUL_VVT;
            dix_pkg::S_MUL_VVT:
            begin
                if (step_last)
                    state_next = dix_pkg::S_NOW_DONE;
            end
            dix_pkg::S_NOW_DONE:
            begin
                if (first_reg)
                    state_next = dix_pkg::S_FINISH;
                else if (neg_dvh)
                    state_next = dix_pkg::S_PUBLISH;
                else
                    state_next = dix_pkg::S_MUL_DT;
            end
            dix_pkg::S_MUL_DT:
            begin
                if (step_last)
                    state_next = dix_pkg::S_SQRT_T;
            end
            dix_pkg::S_SQRT_T:
            begin
                if (step_last)
                    state_next = dix_pkg::S_DIV_WAIT;
            end
            dix_pkg::S_DIV_WAIT:
            begin
                if (dcnt_reg == '0)
                    state_next = dix_pkg::S_SQRT_V;
            end
            dix_pkg::S_SQRT_V:
            begin
                if (step_last)
                    state_next = dix_pkg::S_FINISH;
            end
            dix_pkg::S_FINISH:
                state_next = dix_pkg::S_PUBLISH;
            dix_pkg::S_PUBLISH:
            begin
                if (can_pub)
                    state_next = dix_pkg::S_IDLE;
            end
            default:
                state_next = dix_pkg::S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        in_ready  = 1'b0;
        div_start = 1'b0;
        pub_fire  = 1'b0;
        state_upd = 1'b0;
        unique case (state_reg)
            dix_pkg::S_IDLE:     in_ready  = 1'b1;
            dix_pkg::S_NOW_DONE: div_start = !first_reg && !neg_dvh;
            dix_pkg::S_FINISH:   state_upd = 1'b1;
            dix_pkg::S_PUBLISH:  pub_fire  = can_pub;
            default: ;
        endcase
    end

    // Control registers and stored layer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dix_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            dcnt_reg      <= '0;
            prev_time_reg <= '0;
            prev_prod_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;

            // Hold the result word until it is taken
            if (pub_fire)
                out_valid_reg <= 1'b1;
            else if (out_word.ready)
                out_valid_reg <= 1'b0;

            // Advance the divider count
            if (div_start)
                dcnt_reg <= DW'(PW);
            else if (dcnt_reg != '0)
                dcnt_reg <= dcnt_reg - DW'(1);

            // Keep the pick of every valid layer
            if (state_upd)
            begin
                prev_time_reg <= t_reg;
                prev_prod_reg <= now_reg;
            end
        end
    end

    // Divider datapath
    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            dnum_reg <= dvh;
            drem_reg <= '0;
            dden_reg <= dt_now;
        end
        else if (dcnt_reg != '0)
        begin
            dnum_reg <= {dnum_reg[PW-2:0], dfit};
            drem_reg <= dfit ? ddiff[TW-1:0] : dtrial[TW-1:0];
        end
    end

    // Main datapath
    always_ff @(posedge clk)
    begin
        if (in_word.valid && in_ready)
        begin
            v_reg     <= in_word.stack_velocity;
            t_reg     <= in_word.zero_offset_time;
            first_reg <= in_word.first_layer;
        end

        unique case (state_reg)
            dix_pkg::S_CHECK:
            begin
                mcand_reg      <= QW'(t_reg);
                mplier_reg     <= BW'(v_reg);
                acc_reg        <= '0;
                kcnt_reg       <= KW'(VW);
                res_thick_reg  <= '0;
                res_vel_reg    <= '0;
                res_status_reg <= zero_in ? dix_pkg::ST_ZERO_INPUT : dix_pkg::ST_TIME_ORDER;
            end
            dix_pkg::S_MUL_VT, dix_pkg::S_MUL_VVT:
            begin
                acc_reg    <= acc_step;
                mcand_reg  <= mcand_reg << 1;
                mplier_reg <= mplier_reg >> 1;
                kcnt_reg   <= kcnt_reg - KW'(1);
            end
            dix_pkg::S_VT_DONE:
            begin
                vt_reg     <= acc_reg[VTW-1:0];
                mcand_reg  <= QW'(acc_reg[VTW-1:0]);
                mplier_reg <= BW'(v_reg);
                acc_reg    <= '0;
                kcnt_reg   <= KW'(VW);
            end
            dix_pkg::S_NOW_DONE:
            begin
                now_reg        <= acc_reg[PW-1:0];
                mcand_reg      <= QW'(dvh);
                mplier_reg     <= BW'(dt_now);
                acc_reg        <= '0;
                kcnt_reg       <= KW'(TW);
                res_thick_reg  <= '0;
                res_vel_reg    <= '0;
                res_status_reg <= dix_pkg::ST_NEG_DVH;
            end
            dix_pkg::S_MUL_DT:
            begin
                acc_reg    <= acc_step;
                mcand_reg  <= mcand_reg << 1;
                mplier_reg <= mplier_reg >> 1;
                // Hand dvh*dt straight to the root unit on the last step
                if (step_last)
                begin
                    sx_reg    <= SW'(acc_step);
                    srem_reg  <= '0;
                    sroot_reg <= '0;
                    kcnt_reg  <= KW'(RW);
                end
                else
                begin
                    kcnt_reg <= kcnt_reg - KW'(1);
                end
            end
            dix_pkg::S_SQRT_T, dix_pkg::S_SQRT_V:
            begin
                sx_reg    <= sx_reg << 2;
                srem_reg  <= sfit ? sdiff[RW+1:0] : strial[RW+1:0];
                sroot_reg <= {sroot_reg[RW-2:0], sfit};
                kcnt_reg  <= kcnt_reg - KW'(1);
            end
            dix_pkg::S_DIV_WAIT:
            begin
                root_t_reg <= sroot_reg;
                // Start the velocity root once the quotient is complete
                if (dcnt_reg == '0)
                begin
                    sx_reg    <= SW'(dnum_reg) << QSH;
                    srem_reg  <= '0;
                    sroot_reg <= '0;
                    kcnt_reg  <= KW'(RQ);
                end
            end
            dix_pkg::S_FINISH:
            begin
                res_thick_reg  <= thick_sat ? {TW{1'b1}} : thick_wide[TW-1:0];
                res_vel_reg    <= vel_sat ? {VW{1'b1}} : vel_wide[VW-1:0];
                res_status_reg <= (thick_sat || vel_sat) ? dix_pkg::ST_SATURATED
                                                         : dix_pkg::ST_OK;
            end
            default: ;
        endcase

        // Load the output word
        if (pub_fire)
        begin
            out_thick_reg  <= res_thick_reg;
            out_vel_reg    <= res_vel_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign in_word.ready              = in_ready;
    assign out_word.valid             = out_valid_reg;
    assign out_word.layer_thickness   = out_thick_reg;
    assign out_word.interval_velocity = out_vel_reg;
    assign out_word.status            = out_status_reg;

endmodule

// ===== src/dix_chk.sv =====
`timescale 1ns / 1ps
// Port-level checker for the Dix interval velocity core, with its bind.
module dix_chk #(
    parameter int VELOCITY_BITS = dix_pkg::VELOCITY_BITS,
    parameter int TIME_BITS     = dix_pkg::TIME_BITS
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [TIME_BITS-1:0]            layer_thickness,
    input logic [VELOCITY_BITS-1:0]        interval_velocity,
    input logic [dix_pkg::STATUS_BITS-1:0] status
);

    // Count words taken in and not yet delivered
    logic [1:0] pend_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else
            pend_reg <= pend_reg + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
    end

    // A stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(layer_thickness)
            && $stable(interval_velocity) && $stable(status))
        else $error("result word changed while stalled");

    // No result word without a pick behind it
    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 2'd0)
        else $error("result word without an accepted pick");

    // At most one pick in work beside one waiting result
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd3)
        else $error("too many picks in flight");

    // Rejected picks carry zero values
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == dix_pkg::ST_ZERO_INPUT || status == dix_pkg::ST_TIME_ORDER
            || status == dix_pkg::ST_NEG_DVH)
        |-> layer_thickness == '0 && interval_velocity == '0)
        else $error("rejected pick with nonzero values");

endmodule

bind dix_interval_velocity_core dix_chk #(
    .VELOCITY_BITS(VELOCITY_BITS),
    .TIME_BITS(TIME_BITS)
) u_dix_chk (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_word.valid),
    .in_ready(in_word.ready),
    .out_valid(out_word.valid),
    .out_ready(out_word.ready),
    .layer_thickness(out_word.layer_thickness),
    .interval_velocity(out_word.interval_velocity),
    .status(out_word.status)
);
